@@ design/spi_register_access_master_core_macros.svh @@
// Assertion macros shared by the SPI register-access master files.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef SPI_REGISTER_ACCESS_MASTER_CORE_MACROS_SVH
`define SPI_REGISTER_ACCESS_MASTER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define SPIRM_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("SPI master check failed");

// Next-cycle implication.
`define SPIRM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("SPI master check failed");

`else

`define SPIRM_ASSERT_IMPL(name, ante, cons)
`define SPIRM_ASSERT_NEXT(name, ante, cons)

`endif

`endif

@@ design/spirm_pkg.sv @@
package spirm_pkg;

    // Largest number of data bytes in one transaction.
    localparam logic [2:0] MAX_BYTES = 3'd4;

    // Command codes carried with each tick.
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_UPDATE = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] CFG_READ_SETUP  = 2'd1;
    localparam logic [1:0] CFG_END_GAP     = 2'd2;

    // Configuration reset values.
    localparam logic [7:0]  HALF_PERIOD_RST = 8'd1;
    localparam logic [15:0] READ_SETUP_RST  = 16'd100;
    localparam logic [15:0] END_GAP_RST     = 16'd1000;

    // Update command: one byte of 0x01 to register 0x232.
    localparam logic [12:0] UPDATE_ADDR = 13'h232;
    localparam logic [31:0] UPDATE_DATA = 32'h0000_0001;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_OLOW,
        ST_OHIGH,
        ST_RHIGH,
        ST_RLOW,
        ST_GAP
    } spirm_state_t;

    // One input tick and its optional command.
    typedef struct packed {
        logic [1:0]  op;
        logic [12:0] reg_address;
        logic [1:0]  transfer_mode;
        logic [2:0]  byte_count;
        logic [31:0] write_data;
        logic        miso_in;
    } spirm_item_t;

    // Timing configuration.
    typedef struct packed {
        logic [7:0]  half_period_ticks;
        logic [15:0] read_setup_ticks;
        logic [15:0] end_gap_ticks;
    } spirm_cfg_t;

    // Pin levels and status after one tick.
    typedef struct packed {
        logic        sck_out;
        logic        mosi_out;
        logic        cs_n_out;
        logic        busy_res;
        logic        done_res;
        logic [31:0] read_data;
    } spirm_result_t;

endpackage

@@ design/spirm_seq.sv @@
module spirm_seq
    import spirm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  spirm_item_t   item,
    input  spirm_cfg_t    cfg,
    output spirm_result_t result
);

    spirm_state_t state_reg, state_next;
    logic [47:0] out_shift_reg, out_shift_next;
    logic [31:0] in_shift_reg, in_shift_next;
    logic [5:0]  bits_left_reg, bits_left_next;
    logic [15:0] phase_count_reg, phase_count_next;
    logic        is_read_reg, is_read_next;
    logic        sck_reg, sck_next;
    logic        cs_reg, cs_next;
    logic        mosi_reg, mosi_next;
    logic [2:0]  read_bytes_reg, read_bytes_next;

    logic [15:0] half_m1;
    logic [2:0]  n_clamp;
    logic [2:0]  n_eff;
    logic [31:0] wd_eff;
    logic [31:0] wd_aligned;
    logic [15:0] instr;
    logic [5:0]  bits_dec;
    logic [47:0] out_shifted;

    // Half period minus one, with a zero setting acting as one.
    assign half_m1 = (cfg.half_period_ticks == 8'd0) ? 16'd0
                   : {8'd0, cfg.half_period_ticks - 8'd1};

    // Byte count forced into 1..MAX_BYTES.
    assign n_clamp = (item.byte_count == 3'd0) ? 3'd1
                   : (item.byte_count > MAX_BYTES) ? MAX_BYTES : item.byte_count;

    // Update overrides address, mode, data and length.
    always_comb
    begin
        if (item.op == OP_UPDATE)
        begin
            n_eff  = 3'd1;
            wd_eff = UPDATE_DATA;
            instr  = {3'b000, UPDATE_ADDR};
        end
        else
        begin
            n_eff  = n_clamp;
            wd_eff = item.write_data;
            instr  = {(item.op == OP_READ), item.transfer_mode, item.reg_address};
        end
    end

    // Place the used write bytes at the top of the data word.
    always_comb
    begin
        case (n_eff)
            3'd1:    wd_aligned = {wd_eff[7:0], 24'd0};
            3'd2:    wd_aligned = {wd_eff[15:0], 16'd0};
            3'd3:    wd_aligned = {wd_eff[23:0], 8'd0};
            default: wd_aligned = wd_eff;
        endcase
    end

    assign bits_dec    = (bits_left_reg != 6'd0) ? bits_left_reg - 6'd1 : 6'd0;
    assign out_shifted = {out_shift_reg[46:0], 1'b0};

    // Next state and pin levels for one tick.
    always_comb
    begin
        state_next       = state_reg;
        out_shift_next   = out_shift_reg;
        in_shift_next    = in_shift_reg;
        bits_left_next   = bits_left_reg;
        phase_count_next = phase_count_reg;
        is_read_next     = is_read_reg;
        sck_next         = sck_reg;
        cs_next          = cs_reg;
        mosi_next        = mosi_reg;
        read_bytes_next  = read_bytes_reg;
        result.done_res  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.op != OP_TICK)
                begin
                    in_shift_next = 32'd0;
                    cs_next       = 1'b0;
                    state_next    = ST_SETUP;
                    if (item.op == OP_READ)
                    begin
                        is_read_next     = 1'b1;
                        read_bytes_next  = n_eff;
                        bits_left_next   = 6'd16;
                        out_shift_next   = {instr, 32'd0};
                        phase_count_next = cfg.read_setup_ticks;
                    end
                    else
                    begin
                        is_read_next     = 1'b0;
                        read_bytes_next  = 3'd0;
                        bits_left_next   = 6'd16 + {n_eff, 3'b000};
                        out_shift_next   = {instr, wd_aligned};
                        phase_count_next = 16'd0;
                    end
                end
            end
            ST_SETUP:
            begin
                if (phase_count_reg == 16'd0)
                begin
                    sck_next         = 1'b0;
                    mosi_next        = out_shift_reg[47];
                    phase_count_next = half_m1;
                    state_next       = ST_OLOW;
                end
                else
                begin
                    phase_count_next = phase_count_reg - 16'd1;
                end
            end
            ST_OLOW:
            begin
                if (phase_count_reg == 16'd0)
                begin
                    sck_next         = 1'b1;
                    phase_count_next = half_m1;
                    state_next       = ST_OHIGH;
                end
                else
                begin
                    phase_count_next = phase_count_reg - 16'd1;
                end
            end
            ST_OHIGH:
            begin
                if (phase_count_reg == 16'd0)
                begin
                    out_shift_next = out_shifted;
                    bits_left_next = bits_dec;
                    if (bits_dec != 6'd0)
                    begin
                        // Next output bit.
                        sck_next         = 1'b0;
                        mosi_next        = out_shifted[47];
                        phase_count_next = half_m1;
                        state_next       = ST_OLOW;
                    end
                    else if (is_read_reg && (read_bytes_reg != 3'd0))
                    begin
                        // Instruction sent, turn around to the read phase.
                        bits_left_next   = {read_bytes_reg, 3'b000};
                        mosi_next        = 1'b0;
                        sck_next         = 1'b1;
                        phase_count_next = half_m1;
                        state_next       = ST_RHIGH;
                    end
                    else
                    begin
                        cs_next          = 1'b1;
                        sck_next         = 1'b1;
                        mosi_next        = 1'b0;
                        phase_count_next = cfg.end_gap_ticks;
                        state_next       = ST_GAP;
                    end
                end
                else
                begin
                    phase_count_next = phase_count_reg - 16'd1;
                end
            end
            ST_RHIGH:
            begin
                if (phase_count_reg == 16'd0)
                begin
                    sck_next         = 1'b0;
                    phase_count_next = half_m1;
                    state_next       = ST_RLOW;
                end
                else
                begin
                    phase_count_next = phase_count_reg - 16'd1;
                end
            end
            ST_RLOW:
            begin
                if (phase_count_reg == 16'd0)
                begin
                    // Sample MISO at the end of the low half.
                    in_shift_next  = {in_shift_reg[30:0], item.miso_in};
                    bits_left_next = bits_dec;
                    if (bits_dec != 6'd0)
                    begin
                        sck_next         = 1'b1;
                        phase_count_next = half_m1;
                        state_next       = ST_RHIGH;
                    end
                    else
                    begin
                        cs_next          = 1'b1;
                        sck_next         = 1'b1;
                        mosi_next        = 1'b0;
                        phase_count_next = cfg.end_gap_ticks;
                        state_next       = ST_GAP;
                    end
                end
                else
                begin
                    phase_count_next = phase_count_reg - 16'd1;
                end
            end
            ST_GAP:
            begin
                if (phase_count_reg == 16'd0)
                begin
                    result.done_res = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    phase_count_next = phase_count_reg - 16'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        result.sck_out   = sck_next;
        result.mosi_out  = mosi_next;
        result.cs_n_out  = cs_next;
        result.busy_res  = (state_next != ST_IDLE);
        result.read_data = in_shift_next;
    end

    // State register, advanced once per accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else if (step)
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers of the serial engine.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_shift_reg   <= 48'd0;
            in_shift_reg    <= 32'd0;
            bits_left_reg   <= 6'd0;
            phase_count_reg <= 16'd0;
            is_read_reg     <= 1'b0;
            sck_reg         <= 1'b1;
            cs_reg          <= 1'b1;
            mosi_reg        <= 1'b0;
            read_bytes_reg  <= 3'd0;
        end
        else if (step)
        begin
            out_shift_reg   <= out_shift_next;
            in_shift_reg    <= in_shift_next;
            bits_left_reg   <= bits_left_next;
            phase_count_reg <= phase_count_next;
            is_read_reg     <= is_read_next;
            sck_reg         <= sck_next;
            cs_reg          <= cs_next;
            mosi_reg        <= mosi_next;
            read_bytes_reg  <= read_bytes_next;
        end
    end

endmodule

@@ design/spi_register_access_master_core.sv @@
// Channel   Direction  Handshake                  Payload
// s_*       in         s_tvalid / s_tready        s_tuser op, s_tdata tick fields
// m_*       out        m_tvalid / m_tready        m_tdata pin levels, status, read data
// cfg_*     in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Each input beat is one tick of the serial engine and yields exactly one output beat.
// The engine step and the result register sit in one cycle, so a beat is taken every
// cycle while the output side keeps up; a beat waiting in the result register blocks
// input only when m_tready is low.
// Reset puts the pins at idle levels (SCK high, CS high, MOSI low) and loads the
// configuration defaults; cfg_ready is always high.
`include "spi_register_access_master_core_macros.svh"

module spi_register_access_master_core
    import spirm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input ticks.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // reg_address[12:0], transfer_mode[14:13],
                                  // byte_count[17:15], write_data[49:18], miso_in[50]
    input  logic [1:0]  s_tuser,  // op[1:0]
    // Results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // sck_out[0], mosi_out[1], cs_n_out[2], busy_res[3],
                                  // done_res[4], read_data[36:5]
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    spirm_item_t   item;
    spirm_cfg_t    cfg;
    spirm_result_t result;
    logic          step;

    logic [7:0]  half_period_reg;
    logic [15:0] read_setup_reg;
    logic [15:0] end_gap_reg;
    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;

    // Unpack the input beat.
    assign item.op            = s_tuser;
    assign item.reg_address   = s_tdata[12:0];
    assign item.transfer_mode = s_tdata[14:13];
    assign item.byte_count    = s_tdata[17:15];
    assign item.write_data    = s_tdata[49:18];
    assign item.miso_in       = s_tdata[50];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RST;
            read_setup_reg  <= READ_SETUP_RST;
            end_gap_reg     <= END_GAP_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_HALF_PERIOD: half_period_reg <= cfg_data[7:0];
                CFG_READ_SETUP:  read_setup_reg  <= cfg_data;
                CFG_END_GAP:     end_gap_reg     <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign cfg.half_period_ticks = half_period_reg;
    assign cfg.read_setup_ticks  = read_setup_reg;
    assign cfg.end_gap_ticks     = end_gap_reg;

    spirm_seq u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item),
        .cfg    (cfg),
        .result (result)
    );

    // Result register: loaded on every accepted tick, emptied when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (step)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            m_tdata_reg <= {3'd0, result.read_data, result.done_res, result.busy_res,
                            result.cs_n_out, result.mosi_out, result.sck_out};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Done only follows the end of the gap, with the bus released.
    `SPIRM_ASSERT_IMPL(a_done_idle, m_tvalid_reg && m_tdata_reg[4], !m_tdata_reg[3])
    `SPIRM_ASSERT_IMPL(a_done_pins, m_tvalid_reg && m_tdata_reg[4],
                       m_tdata_reg[2] && m_tdata_reg[0])
    // Chip select is only low during a running transaction.
    `SPIRM_ASSERT_IMPL(a_cs_busy, m_tvalid_reg && !m_tdata_reg[2], m_tdata_reg[3])
    // Every accepted tick leaves a result behind.
    `SPIRM_ASSERT_NEXT(a_step_result, step, m_tvalid_reg)

endmodule
